// ===== rtl/extent_list_coalescer_unit_macros.svh =====
// Assertion shorthands used by the coalescer unit.
`ifndef EXTENT_LIST_COALESCER_UNIT_MACROS_SVH
`define EXTENT_LIST_COALESCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ELC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ELC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/elc_pkg.sv =====
`default_nettype none

package elc_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;

    localparam int ACT_W    = 2;
    localparam int OFF_IN_W = 62;
    localparam int LEN_IN_W = 62;
    localparam int KIND_W   = 32;
    localparam int RIDX_W   = 10;
    localparam int POS_W    = 63;
    localparam int STS_W    = 3;
    localparam int IDX_O_W  = 10;
    localparam int CNT_O_W  = 11;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [STS_W-1:0] {
        STS_APPEND  = 3'd0,
        STS_MERGE   = 3'd1,
        STS_IGNORE  = 3'd2,
        STS_GAP     = 3'd3,
        STS_LATE    = 3'd4,
        STS_READ    = 3'd5,
        STS_BADIDX  = 3'd6,
        STS_CLEARED = 3'd7
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 1'b1;

    // Write strobes into the entry store.
    typedef struct packed {
        logic entry_we;  // write offset, length and kind
        logic len_we;    // write length only (coalesce)
    } wr_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/extent_list_coalescer_unit.sv =====
// Extent list coalescer.
// Input channel s_*: one word per command (add extent, read entry, clear
// list, no-op). Result channel m_*: exactly one word per command, in order.
// Configuration: cfg_wr_en/cfg_index/cfg_data write range_start (index 0)
// or range_end (index 1) at a clock edge; write only while idle.
// From input accept to result valid, add passes CALC (end sum), CLIP
// (clip/compare) and COMMIT (coalesce add and write-back); read, clear
// and no-op go straight to COMMIT (the synchronous memory read overlaps
// the accept cycle).
// One command is in flight at a time; s_ready is high only when idle, so
// a new command is not taken until the previous one has committed.
// The last stored entry is shadowed in registers, so coalescing needs no
// memory read; entries live in a single-port-write, one-read memory.
// Reset (aresetn low, synchronous) empties the list, forgets the expected
// offset and clears both range registers; memory contents are not cleared
// (entries beyond the count are never returned).
// When the receiver stalls, the result word holds in the output register;
// a finished command waits in its commit step until the register frees.
`default_nettype none
`include "extent_list_coalescer_unit_macros.svh"

module extent_list_coalescer_unit #(
    parameter int MAX_ENTRIES = elc_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [elc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [elc_pkg::POS_W-1:0]     cfg_data,
    // input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [elc_pkg::ACT_W-1:0]     s_action,
    input  wire logic [elc_pkg::OFF_IN_W-1:0]  s_offset,
    input  wire logic [elc_pkg::LEN_IN_W-1:0]  s_length,
    input  wire logic [elc_pkg::KIND_W-1:0]    s_kind,
    input  wire logic [elc_pkg::RIDX_W-1:0]    s_read_index,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [elc_pkg::STS_W-1:0]          m_status,
    output logic [elc_pkg::IDX_O_W-1:0]        m_entry_index,
    output logic [elc_pkg::POS_W-1:0]          m_entry_offset,
    output logic [elc_pkg::POS_W-1:0]          m_entry_length,
    output logic [elc_pkg::KIND_W-1:0]         m_entry_kind,
    output logic [elc_pkg::CNT_O_W-1:0]        m_entry_count
);
    import elc_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CALC   = 4'b0010,
        S_CLIP   = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Range registers.
    logic [POS_W-1:0] range_start_reg, range_end_reg;

    // Captured command word.
    action_t            act_reg;
    logic [OFF_IN_W-1:0] off_reg;
    logic [LEN_IN_W-1:0] len_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [RIDX_W-1:0]  ridx_reg;

    // Add pipeline intermediates.
    logic [POS_W-1:0] end_reg;
    logic             gap_reg, skip_reg, late_reg, low_reg, merge_reg;
    logic [POS_W-1:0] nlen_reg, noff_reg;

    // List state and shadow of the last stored entry.
    logic [CW-1:0]     count_reg, count_next;
    logic [POS_W-1:0]  exp_off_reg;
    logic              exp_valid_reg;
    logic [KIND_W-1:0] last_kind_reg;
    logic [POS_W-1:0]  last_len_reg, last_off_reg;

    // Output register.
    logic              m_valid_reg;
    status_t           sts_reg;
    logic [IDX_O_W-1:0] idx_o_reg;
    logic [POS_W-1:0]  off_o_reg, len_o_reg;
    logic [KIND_W-1:0] kind_o_reg;
    logic [CNT_O_W-1:0] cnt_o_reg;

    // Store interface.
    wr_ctl_t           wr_ctl;
    logic [AW-1:0]     wr_addr;
    logic [POS_W-1:0]  wr_offset, wr_length;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [POS_W-1:0]  rd_offset, rd_length;
    logic [KIND_W-1:0] rd_kind;

    logic s_accept, out_free, commit, first, full;
    logic [POS_W-1:0] off_ext, clip_end, merge_len;

    // Commit decision.
    status_t           sts_next;
    logic [AW-1:0]     idx_next;
    logic [POS_W-1:0]  off_o_next, len_o_next;
    logic [KIND_W-1:0] kind_o_next;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == S_COMMIT) && out_free;
    assign first    = (count_reg == '0);
    assign full     = (count_reg == CW'(MAX_ENTRIES));
    assign off_ext  = {1'b0, off_reg};
    assign clip_end = (end_reg > range_end_reg) ? range_end_reg : end_reg;
    assign merge_len = last_len_reg + nlen_reg;

    // Issue the memory read as the read word is accepted.
    assign rd_en   = s_accept && (action_t'(s_action) == ACT_READ);
    assign rd_addr = AW'(s_read_index);

    elc_store #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .AW(AW)
    ) u_store (
        .aclk      (aclk),
        .wr_ctl    (wr_ctl),
        .wr_addr   (wr_addr),
        .wr_offset (wr_offset),
        .wr_length (wr_length),
        .wr_kind   (kind_reg),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_offset (rd_offset),
        .rd_length (rd_length),
        .rd_kind   (rd_kind)
    );

    // Sequencer: add walks CALC -> CLIP -> COMMIT, others go straight to COMMIT.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = (action_t'(s_action) == ACT_ADD) ? S_CALC : S_COMMIT;
                end
            end
            S_CALC:   state_next = S_CLIP;
            S_CLIP:   state_next = S_COMMIT;
            S_COMMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Decide the result word and the write-back for the command in COMMIT.
    always_comb begin
        sts_next    = STS_IGNORE;
        idx_next    = '0;
        off_o_next  = '0;
        len_o_next  = '0;
        kind_o_next = '0;
        count_next  = count_reg;
        wr_ctl      = '0;
        wr_addr     = AW'(count_reg);
        wr_offset   = noff_reg;
        wr_length   = nlen_reg;
        case (act_reg)
            ACT_ADD: begin
                if (gap_reg) begin
                    sts_next = STS_GAP;
                end else if (skip_reg || (first && low_reg)) begin
                    sts_next = STS_IGNORE;
                end else if (first && late_reg) begin
                    sts_next = STS_LATE;
                end else if (merge_reg) begin
                    // Coalesce into the last entry: length update only.
                    sts_next      = STS_MERGE;
                    idx_next      = AW'(count_reg - CW'(1));
                    off_o_next    = last_off_reg;
                    len_o_next    = merge_len;
                    kind_o_next   = kind_reg;
                    wr_addr       = AW'(count_reg - CW'(1));
                    wr_length     = merge_len;
                    wr_ctl.len_we = commit;
                end else begin
                    sts_next        = STS_APPEND;
                    idx_next        = AW'(count_reg);
                    off_o_next      = noff_reg;
                    len_o_next      = nlen_reg;
                    kind_o_next     = kind_reg;
                    count_next      = count_reg + CW'(1);
                    wr_ctl.entry_we = commit;
                end
            end
            ACT_READ: begin
                idx_next = AW'(ridx_reg);
                if (32'(ridx_reg) < 32'(count_reg)) begin
                    sts_next    = STS_READ;
                    off_o_next  = rd_offset;
                    len_o_next  = rd_length;
                    kind_o_next = rd_kind;
                end else begin
                    sts_next = STS_BADIDX;
                end
            end
            ACT_CLEAR: begin
                sts_next   = STS_CLEARED;
                count_next = '0;
            end
            default: begin
                sts_next = STS_IGNORE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            range_start_reg <= '0;
            range_end_reg   <= '0;
            count_reg       <= '0;
            exp_off_reg     <= '0;
            exp_valid_reg   <= 1'b0;
            last_kind_reg   <= '0;
            last_len_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_RANGE_START: range_start_reg <= cfg_data;
                    CFG_RANGE_END:   range_end_reg   <= cfg_data;
                    default:         ;
                endcase
            end

            if (commit) begin
                count_reg <= count_next;
                case (act_reg)
                    ACT_ADD: begin
                        if (!gap_reg) begin
                            // Advance the expected offset even when dropped.
                            exp_off_reg   <= end_reg;
                            exp_valid_reg <= 1'b1;
                        end
                        if (sts_next == STS_MERGE) begin
                            last_len_reg <= merge_len;
                        end else if (sts_next == STS_APPEND) begin
                            last_len_reg  <= nlen_reg;
                            last_kind_reg <= kind_reg;
                        end
                    end
                    ACT_CLEAR: begin
                        exp_off_reg   <= '0;
                        exp_valid_reg <= 1'b0;
                        last_kind_reg <= '0;
                        last_len_reg  <= '0;
                    end
                    default: ;
                endcase
            end

            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and pipeline registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg  <= action_t'(s_action);
            off_reg  <= s_offset;
            len_reg  <= s_length;
            kind_reg <= s_kind;
            ridx_reg <= s_read_index;
        end

        if (state_reg == S_CALC) begin
            end_reg  <= off_ext + {1'b0, len_reg};
            gap_reg  <= exp_valid_reg && (exp_off_reg != off_ext);
            skip_reg <= (len_reg == '0) || (off_ext >= range_end_reg) || full;
            late_reg <= off_ext > range_start_reg;
        end

        if (state_reg == S_CLIP) begin
            low_reg   <= clip_end <= range_start_reg;
            nlen_reg  <= first ? (clip_end - range_start_reg) : (clip_end - off_ext);
            noff_reg  <= first ? range_start_reg : off_ext;
            merge_reg <= !first && (last_kind_reg == kind_reg);
        end

        if (commit && (sts_next == STS_APPEND)) begin
            last_off_reg <= noff_reg;
        end

        if (commit) begin
            sts_reg    <= sts_next;
            idx_o_reg  <= IDX_O_W'(idx_next);
            off_o_reg  <= off_o_next;
            len_o_reg  <= len_o_next;
            kind_o_reg <= kind_o_next;
            cnt_o_reg  <= CNT_O_W'(count_next);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = sts_reg;
    assign m_entry_index  = idx_o_reg;
    assign m_entry_offset = off_o_reg;
    assign m_entry_length = len_o_reg;
    assign m_entry_kind   = kind_o_reg;
    assign m_entry_count  = cnt_o_reg;

    `ELC_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(MAX_ENTRIES), "entry count above capacity")
    `ELC_ASSERT_NXT(a_accept_busy, aclk, aresetn, s_accept, !s_ready, "second word accepted while busy")
    `ELC_ASSERT_NXT(a_commit_hold, aclk, aresetn, (state_reg == S_COMMIT) && !out_free, state_reg == S_COMMIT, "commit left while output slot full")
    `ELC_ASSERT_IMP(a_merge_nonempty, aclk, aresetn, m_valid && (m_status == STS_MERGE), m_entry_count != '0, "coalesce reported on empty list")

endmodule

`default_nettype wire

// ===== rtl/elc_store.sv =====
`default_nettype none

module elc_store #(
    parameter int MAX_ENTRIES = elc_pkg::MAX_ENTRIES_DEF,
    parameter int AW = 10
) (
    input  wire logic                      aclk,
    input  wire elc_pkg::wr_ctl_t          wr_ctl,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [elc_pkg::POS_W-1:0] wr_offset,
    input  wire logic [elc_pkg::POS_W-1:0] wr_length,
    input  wire logic [elc_pkg::KIND_W-1:0] wr_kind,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    output logic [elc_pkg::POS_W-1:0]      rd_offset,
    output logic [elc_pkg::POS_W-1:0]      rd_length,
    output logic [elc_pkg::KIND_W-1:0]     rd_kind
);
    import elc_pkg::*;

    logic [POS_W-1:0]  off_mem  [MAX_ENTRIES];
    logic [POS_W-1:0]  len_mem  [MAX_ENTRIES];
    logic [KIND_W-1:0] kind_mem [MAX_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_ctl.entry_we) begin
            off_mem[wr_addr]  <= wr_offset;
            kind_mem[wr_addr] <= wr_kind;
        end
        if (wr_ctl.entry_we || wr_ctl.len_we) begin
            len_mem[wr_addr] <= wr_length;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_offset <= off_mem[rd_addr];
            rd_length <= len_mem[rd_addr];
            rd_kind   <= kind_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
